// ----- rtl/core/awma_pkg.sv -----
// ----------------------------------------------------------------------------
// Moving average package
// Shared constants, action codes and request types for the adjustable window
// moving average block.
// ----------------------------------------------------------------------------
package awma_pkg;

    // Number of samples kept in the history.
    localparam int HISTORY_DEPTH = 16;
    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    // Width of the window length and sample count (holds HISTORY_DEPTH itself).
    localparam int CNT_W = 5;
    localparam int SAMPLE_W = 8;
    // The sum of a full window of signed samples.
    localparam int SUM_W = SAMPLE_W + PTR_W;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_WIDEN  = 2'd1;
    localparam logic [1:0] ACT_NARROW = 2'd2;

    typedef struct packed {
        logic [1:0]                 action;
        logic signed [SAMPLE_W-1:0] sample_value;
    } awma_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] average_value;
        logic [CNT_W-1:0]           window_in_use;
    } awma_out_t;

endpackage

// ----- rtl/core/awma_div.sv -----
// ----------------------------------------------------------------------------
// Moving average divider
// Iterative restoring divider: one quotient bit a cycle, signed result
// truncated toward zero.
// ----------------------------------------------------------------------------
module awma_div (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic signed [awma_pkg::SUM_W-1:0]      dividend,
    input  logic [awma_pkg::CNT_W-1:0]             divisor,
    output logic                                   done,
    output logic signed [awma_pkg::SAMPLE_W-1:0]   quotient
);
    import awma_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [SUM_W-1:0]    quo_reg;
    logic [CNT_W-1:0]    divisor_reg;
    logic                neg_reg;

    logic [CNT_W:0]      trial;
    logic                fits;
    logic [CNT_W:0]      diff;
    logic [SUM_W-1:0]    signed_quo;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg     <= '0;
            neg_reg     <= dividend[SUM_W-1];
            // The magnitude of the most negative sum still fits unsigned.
            quo_reg     <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = signed_quo[SAMPLE_W-1:0];
    assign done       = done_reg;

endmodule

// ----- rtl/core/adjustable_window_moving_average_top.sv -----
// ----------------------------------------------------------------------------
// Adjustable window moving average
// Keeps a history of signed samples and returns the truncated mean of the
// newest N (all held if fewer); command requests widen or narrow N by one.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload        Handshake
//  s_        in         awma_in_t      s_valid / s_ready
//  m_        out        awma_out_t     m_valid / m_ready
//
// A sample request walks the history through its single read port, then
// runs the sum through the bit-serial divider and hands over the result.
// Window commands produce no result. Reset clears the write pointer and the
// held-sample count and sets the window to one; the history itself is not
// cleared. s_ready is high only while the sequencer is idle, and a result
// held by m_ready low stalls only the next sample.
// ----------------------------------------------------------------------------
module adjustable_window_moving_average_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  awma_pkg::awma_in_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output awma_pkg::awma_out_t   m_data
);
    import awma_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [PTR_W-1:0] PTR_MAX   = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(HISTORY_DEPTH);

    logic signed [SAMPLE_W-1:0] history_mem [HISTORY_DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    logic [1:0]          state_reg, state_next;
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [CNT_W-1:0]    window_reg, window_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    issued_reg, issued_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic                pend_reg, pend_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [SAMPLE_W-1:0] avg_reg, avg_next;
    logic                m_valid_reg, m_valid_next;
    awma_out_t           m_data_reg, m_data_next;

    logic                s_accept;
    logic                wr_en;
    logic                rd_en;
    logic                div_start;
    logic                div_done;
    logic signed [SAMPLE_W-1:0] div_quotient;
    logic [CNT_W-1:0]    held_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign held_inc = (held_reg < CNT_DEPTH) ? held_reg + 1'b1 : held_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            history_mem[wr_ptr_reg] <= s_data.sample_value;
        end
        if (rd_en) begin
            rd_data_reg <= history_mem[rd_ptr_reg];
        end
    end

    always_comb begin
        state_next   = state_reg;
        wr_ptr_next  = wr_ptr_reg;
        held_next    = held_reg;
        window_next  = window_reg;
        count_next   = count_reg;
        issued_next  = issued_reg;
        rd_ptr_next  = rd_ptr_reg;
        pend_next    = 1'b0;
        sum_next     = sum_reg;
        avg_next     = avg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        div_start    = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_data.action)
                        ACT_SAMPLE: begin
                            wr_en       = 1'b1;
                            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
                            held_next   = held_inc;
                            count_next  = (held_inc < window_reg) ? held_inc : window_reg;
                            rd_ptr_next = wr_ptr_reg;
                            issued_next = '0;
                            sum_next    = '0;
                            state_next  = ST_SUM;
                        end
                        ACT_WIDEN: begin
                            if (window_reg < CNT_DEPTH) begin
                                window_next = window_reg + 1'b1;
                            end
                        end
                        ACT_NARROW: begin
                            if (window_reg > CNT_W'(1)) begin
                                window_next = window_reg - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SUM: begin
                // Reads are issued newest first; each is added to the sum in the following cycle.
                if (issued_reg < count_reg) begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    issued_next = issued_reg + 1'b1;
                    rd_ptr_next = (rd_ptr_reg == '0) ? PTR_MAX : rd_ptr_reg - 1'b1;
                end
                if (pend_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                end else if (issued_reg == count_reg) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next   = div_quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_data_next.average_value = avg_reg;
                    m_data_next.window_in_use = window_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wr_ptr_reg  <= '0;
            held_reg    <= '0;
            window_reg  <= CNT_W'(1);
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wr_ptr_reg  <= wr_ptr_next;
            held_reg    <= held_next;
            window_reg  <= window_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg  <= count_next;
        issued_reg <= issued_next;
        rd_ptr_reg <= rd_ptr_next;
        sum_reg    <= sum_next;
        avg_reg    <= avg_next;
        m_data_reg <= m_data_next;
    end

    awma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
